FILE: sv/mdstg_pkg.sv
package mdstg_pkg;

   localparam int OUT_BITS     = 8;
   localparam int FIELD_PERIOD = 16;
   localparam logic [7:0] MAX_POSITION_RESET = 8'd158;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_SET    = 2'd1,
      ACT_HOME   = 2'd2,
      ACT_UNUSED = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]              action;
      logic [2:0]              drive;
      logic [FIELD_PERIOD-1:0] period;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] step_levels;
      logic [OUT_BITS-1:0] direction_levels;
      logic [OUT_BITS-1:0] fired_mask;
   } rsp_type;

endpackage

FILE: sv/mdstg_ram.sv
module mdstg_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/mdstg_step.sv
// Next state of one drive for a tick: advance counter, and on a match
// toggle, turn at the ends and move the head one half-track.
module mdstg_step #(
   parameter int PERIOD_BITS = 16
) (
   input  logic [PERIOD_BITS-1:0] period,
   input  logic [PERIOD_BITS-1:0] tick_count,
   input  logic [7:0]             position,
   input  logic                   backward,
   input  logic [7:0]             max_position,
   output logic                   fire,
   output logic [PERIOD_BITS-1:0] tick_count_next,
   output logic [7:0]             position_next,
   output logic                   backward_next
);

   logic [PERIOD_BITS-1:0] tick_inc;
   logic                   turn_dir;

   assign tick_inc = tick_count + PERIOD_BITS'(1);
   assign fire     = (period != '0) && (tick_inc >= period);

   always_comb begin
      priority if (position >= max_position) begin
         turn_dir = 1'b1;
      end else if (position == 8'd0) begin
         turn_dir = 1'b0;
      end else begin
         turn_dir = backward;
      end
   end

   always_comb begin
      if (fire) begin
         tick_count_next = '0;
         backward_next   = turn_dir;
         if (turn_dir) begin
            position_next = (position != 8'd0) ? position - 8'd1 : position;
         end else begin
            position_next = position + 8'd1;
         end
      end else begin
         tick_count_next = tick_inc;
         backward_next   = backward;
         position_next   = position;
      end
   end

endmodule

FILE: sv/multi_drive_step_tone_generator.sv
// Sequence: a tick reads then writes back each drive's entry in turn (S_READ, S_WRITE),
// a set period does so for its one drive, and home, an unused code or a set to a drive
// out of range go straight to S_DONE, which loads the result register once it is free.
// Throughput: one transaction at a time; req_stall holds off new requests until S_IDLE.
// Reset: synchronous, clears control, step and direction levels and the entry
// valid bits, so every drive reads as silent, homed and counter zero at once.
module multi_drive_step_tone_generator
   import mdstg_pkg::*;
#(
   parameter int NUM_DRIVES  = 8,
   parameter int PERIOD_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int AW = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
   localparam int EW = 2 * PERIOD_BITS + 8;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_WRITE,
      S_DONE
   } state_type;

   // Per-drive entry in memory: period, tick counter, head position.
   // Two valid bit sets stand in for clearing: home drops only the period and
   // position half, reset drops both (tick counters survive a home).
   state_type              state_ff;
   action_type             act_ff;
   logic [AW-1:0]          idx_ff;
   logic [PERIOD_BITS-1:0] new_period_ff;
   logic [NUM_DRIVES-1:0]  valid_pp_ff;
   logic [NUM_DRIVES-1:0]  valid_tc_ff;
   logic [NUM_DRIVES-1:0]  step_ff;
   logic [NUM_DRIVES-1:0]  back_ff;
   logic [NUM_DRIVES-1:0]  fired_ff;
   logic [7:0]             max_pos_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   rd_en;
   logic                   wr_en;
   logic [EW-1:0]          rd_data;
   logic [EW-1:0]          wr_data;
   logic [PERIOD_BITS-1:0] cur_period;
   logic [PERIOD_BITS-1:0] cur_tick;
   logic [7:0]             cur_pos;
   logic                   fire;
   logic [PERIOD_BITS-1:0] tick_next;
   logic [7:0]             pos_next;
   logic                   back_next;
   logic                   req_accept;
   logic                   drive_ok;
   logic                   last_drive;
   logic [OUT_BITS-1:0]    step_out;
   logic [OUT_BITS-1:0]    back_out;
   logic [OUT_BITS-1:0]    fired_out;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign drive_ok   = 32'(req_data.drive) < NUM_DRIVES;
   assign last_drive = (idx_ff == AW'(NUM_DRIVES - 1));

   // Entry fields, with invalid halves read as their reset value
   assign cur_period = valid_pp_ff[idx_ff] ? rd_data[EW-1 -: PERIOD_BITS] : '0;
   assign cur_tick   = valid_tc_ff[idx_ff] ? rd_data[8 +: PERIOD_BITS] : '0;
   assign cur_pos    = valid_pp_ff[idx_ff] ? rd_data[7:0] : 8'd0;

   mdstg_step #(
      .PERIOD_BITS (PERIOD_BITS)
   ) u_step (
      .period          (cur_period),
      .tick_count      (cur_tick),
      .position        (cur_pos),
      .backward        (back_ff[idx_ff]),
      .max_position    (max_pos_ff),
      .fire            (fire),
      .tick_count_next (tick_next),
      .position_next   (pos_next),
      .backward_next   (back_next)
   );

   // Read in S_READ, modify and write back in S_WRITE; one entry in flight,
   // so no forwarding is needed. On a tick, a silent drive is left untouched.
   assign rd_en = (state_ff == S_READ);

   always_comb begin
      wr_en   = 1'b0;
      wr_data = {cur_period, cur_tick, cur_pos};
      if (state_ff == S_WRITE) begin
         if (act_ff == ACT_SET) begin
            wr_en   = 1'b1;
            wr_data = {new_period_ff, cur_tick, cur_pos};
         end else if (cur_period != '0) begin
            wr_en   = 1'b1;
            wr_data = {cur_period, tick_next, pos_next};
         end
      end
   end

   mdstg_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_DRIVES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Drives beyond the output width have no bit in the result
   for (genvar g = 0; g < OUT_BITS; g++) begin : g_out
      if (g < NUM_DRIVES) begin : g_live
         assign step_out[g]  = step_ff[g];
         assign back_out[g]  = back_ff[g];
         assign fired_out[g] = fired_ff[g];
      end else begin : g_none
         assign step_out[g]  = 1'b0;
         assign back_out[g]  = 1'b0;
         assign fired_out[g] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= ACT_TICK;
         idx_ff       <= '0;
         valid_pp_ff  <= '0;
         valid_tc_ff  <= '0;
         step_ff      <= '0;
         back_ff      <= '0;
         fired_ff     <= '0;
         max_pos_ff   <= MAX_POSITION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_pos_ff <= csr_wr_data;
         end
         // Drop the held result once taken; S_DONE reloads it instead
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  act_ff        <= action_type'(req_data.action);
                  new_period_ff <= PERIOD_BITS'(req_data.period);
                  fired_ff      <= '0;
                  unique case (action_type'(req_data.action))
                     ACT_TICK: begin
                        idx_ff   <= '0;
                        state_ff <= S_READ;
                     end
                     ACT_SET: begin
                        idx_ff   <= AW'(req_data.drive);
                        state_ff <= drive_ok ? S_READ : S_DONE;
                     end
                     ACT_HOME: begin
                        valid_pp_ff <= '0;
                        step_ff     <= '0;
                        back_ff     <= '0;
                        state_ff    <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (wr_en) begin
                  valid_pp_ff[idx_ff] <= 1'b1;
                  valid_tc_ff[idx_ff] <= 1'b1;
               end
               if (act_ff == ACT_SET) begin
                  state_ff <= S_DONE;
               end else begin
                  if (cur_period != '0) begin
                     fired_ff[idx_ff] <= fire;
                     back_ff[idx_ff]  <= back_next;
                     if (fire) begin
                        step_ff[idx_ff] <= ~step_ff[idx_ff];
                     end
                  end
                  // Advance to the next drive or finish the walk
                  if (last_drive) begin
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff   <= idx_ff + AW'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            S_DONE: begin
               // Hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.step_levels      <= step_out;
                  rsp_ff.direction_levels <= back_out;
                  rsp_ff.fired_mask       <= fired_out;
                  state_ff               <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
